// ===== design/msm_pkg.sv =====
package msm_pkg;

    localparam int UPC_W = 3;

    typedef logic [UPC_W-1:0] t_upc;

    // microprogram addresses
    localparam t_upc U_IDLE     = 3'd0;
    localparam t_upc U_DIV_INIT = 3'd1;
    localparam t_upc U_DIV      = 3'd2;
    localparam t_upc U_MAC_INIT = 3'd3;
    localparam t_upc U_MAC      = 3'd4;
    localparam t_upc U_DRAIN1   = 3'd5;
    localparam t_upc U_DRAIN2   = 3'd6;
    localparam t_upc U_EMIT     = 3'd7;

    typedef enum logic [2:0] {
        J_NEXT,
        J_DISPATCH,
        J_LOOP_DIV,
        J_LOOP_MAC,
        J_HOME
    } t_jcond;

    typedef struct packed {
        logic   accept;
        logic   div_init;
        logic   div_step;
        logic   mac_init;
        logic   mac_step;
        logic   emit;
        t_jcond jcond;
        t_upc   target;
    } t_uword;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic mac_init;
        logic mac_step;
        logic emit;
    } t_ctrl;

    typedef struct packed {
        logic div_more;
        logic mac_more;
    } t_status;

    // control store
    function automatic t_uword prog(input t_upc addr);
        t_uword w;
        w = '0;
        case (addr)
            U_IDLE: begin
                w.accept = 1'b1;
                w.jcond  = J_DISPATCH;
                w.target = U_DIV_INIT;
            end
            U_DIV_INIT: begin
                w.div_init = 1'b1;
                w.jcond    = J_NEXT;
            end
            U_DIV: begin
                w.div_step = 1'b1;
                w.jcond    = J_LOOP_DIV;
                w.target   = U_DIV;
            end
            U_MAC_INIT: begin
                w.mac_init = 1'b1;
                w.jcond    = J_NEXT;
            end
            U_MAC: begin
                w.mac_step = 1'b1;
                w.jcond    = J_LOOP_MAC;
                w.target   = U_MAC;
            end
            U_DRAIN1: begin
                w.jcond = J_NEXT;
            end
            U_DRAIN2: begin
                w.jcond = J_NEXT;
            end
            U_EMIT: begin
                w.emit   = 1'b1;
                w.jcond  = J_HOME;
                w.target = U_IDLE;
            end
            default: begin
                w.jcond  = J_HOME;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== design/matrix_square_mac_core.sv =====
// Squares a dim x dim signed 32-bit matrix held in on-chip storage: C = A * A.
// Request channel: a request is taken on a clock edge with start high and busy
// low. i_action = 0 writes i_a_value as the next element of A (row-major);
// i_action = 1 computes the next element of C (row-major).
// A load finishes in the accept cycle; busy does not rise and another request
// can be taken on the next edge.
// A fetch keeps busy high through these steps, with PW = clog2(MAX_DIM^2 + 1)
// (13 at the default size): PW steps of a bit-serial modulo for the column,
// then one multiply-accumulate per cycle, bounded by the two store read ports,
// then a two-stage drain and an emit step. The result appears on o_c_value /
// o_last_of_matrix with o_strobe high for exactly one cycle, the first cycle
// with busy low again; a new request may be taken in that same cycle. The
// receiver cannot hold off results.
// Config: i_cfg_we writes i_cfg_data into dim; only write while idle. A dim
// of 0 acts as 1, a dim above MAX_DIM acts as MAX_DIM.
// Reset: dim = 64, load and fetch positions zero. Store contents are undefined
// until loaded; no clearing pass is run.
module matrix_square_mac_core #(
    parameter int MAX_DIM = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic signed [31:0] i_a_value,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data,
    output logic               o_strobe,
    output logic signed [31:0] o_c_value,
    output logic               o_last_of_matrix
);

    localparam int DW = $clog2(MAX_DIM + 1);

    logic [6:0]       r_dim;
    logic [DW-1:0]    w_deff;
    msm_pkg::t_ctrl   w_ctrl;
    msm_pkg::t_status w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= 7'd64;
        end else if (i_cfg_we) begin
            r_dim <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_dim == '0) begin
            w_deff = DW'(1);
        end else if (int'(r_dim) > MAX_DIM) begin
            w_deff = DW'(MAX_DIM);
        end else begin
            w_deff = DW'(r_dim);
        end
    end

    msm_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_status (w_status),
        .o_busy   (busy),
        .o_ctrl   (w_ctrl)
    );

    msm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_dim            (w_deff),
        .i_a_value        (i_a_value),
        .i_ctrl           (w_ctrl),
        .o_status         (w_status),
        .o_strobe         (o_strobe),
        .o_c_value        (o_c_value),
        .o_last_of_matrix (o_last_of_matrix)
    );

endmodule

// ===== design/msm_useq.sv =====
module msm_useq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_action,
    input  msm_pkg::t_status i_status,
    output logic             o_busy,
    output msm_pkg::t_ctrl   o_ctrl
);

    msm_pkg::t_upc   r_upc;
    msm_pkg::t_upc   n_upc;
    msm_pkg::t_uword w_word;
    msm_pkg::t_upc   w_inc;

    assign w_word = msm_pkg::prog(r_upc);
    assign w_inc  = msm_pkg::t_upc'(r_upc + 1'b1);

    always_comb begin
        case (w_word.jcond)
            msm_pkg::J_NEXT:     n_upc = w_inc;
            msm_pkg::J_DISPATCH: n_upc = (i_start && i_action) ? w_word.target : r_upc;
            msm_pkg::J_LOOP_DIV: n_upc = i_status.div_more ? w_word.target : w_inc;
            msm_pkg::J_LOOP_MAC: n_upc = i_status.mac_more ? w_word.target : w_inc;
            msm_pkg::J_HOME:     n_upc = w_word.target;
            default:             n_upc = msm_pkg::U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= msm_pkg::U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // loads complete in the accept cycle, no microcode steps needed
    assign o_busy          = !w_word.accept;
    assign o_ctrl.load     = w_word.accept && i_start && !i_action;
    assign o_ctrl.div_init = w_word.div_init;
    assign o_ctrl.div_step = w_word.div_step;
    assign o_ctrl.mac_init = w_word.mac_init;
    assign o_ctrl.mac_step = w_word.mac_step;
    assign o_ctrl.emit     = w_word.emit;

endmodule

// ===== design/msm_datapath.sv =====
module msm_datapath #(
    parameter int MAX_DIM = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [$clog2(MAX_DIM+1)-1:0]   i_dim,
    input  logic signed [31:0]             i_a_value,
    input  msm_pkg::t_ctrl                 i_ctrl,
    output msm_pkg::t_status               o_status,
    output logic                           o_strobe,
    output logic signed [31:0]             o_c_value,
    output logic                           o_last_of_matrix
);

    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (PW > 1) ? $clog2(PW) : 1;

    logic [31:0]     mem [DEPTH];

    logic [2*DW-1:0] w_sq;
    logic [PW-1:0]   w_n;
    logic [PW-1:0]   w_lpos;
    logic [PW:0]     w_lnext;
    logic [PW-1:0]   w_fnorm;
    logic [DW:0]     w_trial;
    logic            w_last;
    logic [PW:0]     w_fnext;
    logic [31:0]     w_prod;

    logic [PW-1:0]   r_lpos;
    logic [PW-1:0]   r_fpos;
    logic [PW-1:0]   r_fcur;
    logic [PW-1:0]   r_dvd;
    logic [DW-1:0]   r_rem;
    logic [CW-1:0]   r_cnt;
    logic [PW-1:0]   r_xa;
    logic [PW-1:0]   r_ya;
    logic [DW-1:0]   r_k;
    logic [31:0]     r_rx;
    logic [31:0]     r_ry;
    logic [31:0]     r_prod;
    logic [31:0]     r_acc;
    logic            r_v1;
    logic            r_v2;
    logic            r_o_valid;
    logic [31:0]     r_o_c;
    logic            r_o_last;

    assign w_sq    = i_dim * i_dim;
    assign w_n     = PW'(w_sq);
    assign w_lpos  = (r_lpos >= w_n) ? '0 : r_lpos;
    assign w_lnext = {1'b0, w_lpos} + 1'b1;
    assign w_fnorm = (r_fpos >= w_n) ? '0 : r_fpos;
    assign w_trial = {r_rem, r_dvd[PW-1]};
    assign w_last  = (r_fcur == w_n - 1'b1);
    assign w_fnext = {1'b0, r_fcur} + 1'b1;
    assign w_prod  = r_rx * r_ry;

    assign o_status.div_more = (r_cnt != '0);
    assign o_status.mac_more = (r_k != i_dim - 1'b1);

    // single write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            mem[w_lpos[AW-1:0]] <= i_a_value;
        end
        if (i_ctrl.mac_step) begin
            r_rx <= mem[r_xa[AW-1:0]];
            r_ry <= mem[r_ya[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpos <= '0;
            r_fpos <= '0;
        end else begin
            if (i_ctrl.load) begin
                r_lpos <= (w_lnext >= {1'b0, w_n}) ? '0 : w_lnext[PW-1:0];
                if (w_lpos == '0) begin
                    r_fpos <= '0;
                end
            end
            if (i_ctrl.emit) begin
                r_fpos <= w_last ? '0 : w_fnext[PW-1:0];
            end
        end
    end

    // column = position mod dim, restoring, one bit per step
    always_ff @(posedge i_clk) begin
        if (i_ctrl.div_init) begin
            r_fcur <= w_fnorm;
            r_dvd  <= w_fnorm;
            r_rem  <= '0;
            r_cnt  <= CW'(PW - 1);
        end else if (i_ctrl.div_step) begin
            r_dvd <= r_dvd << 1;
            r_cnt <= r_cnt - 1'b1;
            if (w_trial >= {1'b0, i_dim}) begin
                r_rem <= DW'(w_trial - {1'b0, i_dim});
            end else begin
                r_rem <= DW'(w_trial);
            end
        end
    end

    // row walk: row*dim + k ; column walk: k*dim + col
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mac_init) begin
            r_xa <= r_fcur - PW'(r_rem);
            r_ya <= PW'(r_rem);
            r_k  <= '0;
        end else if (i_ctrl.mac_step) begin
            r_xa <= r_xa + 1'b1;
            r_ya <= r_ya + PW'(i_dim);
            r_k  <= r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= w_prod;
        end
        if (i_ctrl.mac_init) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_v1      <= i_ctrl.mac_step;
            r_v2      <= r_v1;
            r_o_valid <= i_ctrl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            r_o_c    <= r_acc;
            r_o_last <= w_last;
        end
    end

    assign o_strobe         = r_o_valid;
    assign o_c_value        = r_o_c;
    assign o_last_of_matrix = r_o_last;

`ifndef SYNTH
    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.emit |-> (!r_v1 && !r_v2))
        else $error("result emitted with products still in flight");

    a_acc_follows_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("accumulate without a preceding product");

    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> $past(i_ctrl.emit))
        else $error("result strobe without emit step");

    a_no_load_in_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.mac_step || i_ctrl.div_step) |-> !i_ctrl.load)
        else $error("load taken during a fetch");
`endif

endmodule
